[design/pa_pkg.sv]
// Package for the primitive assembler: widths, mode and register codes,
// and the command and configuration structs shared by the modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pa_pkg;

  localparam int VERTEX_REF_BITS = 16;
  localparam int OUT_REF_W       = 16;
  // References are masked to VERTEX_REF_BITS and then to the output width.
  localparam int REF_W = (VERTEX_REF_BITS < OUT_REF_W) ? VERTEX_REF_BITS : OUT_REF_W;

  localparam int CFG_DATA_W = 2;
  localparam int SEEN_W     = 2;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef logic [REF_W-1:0] vref_t;

  typedef enum logic [1:0] {
    MODE_LINE_STRIP = 2'd0,
    MODE_LINE_LOOP  = 2'd1,
    MODE_TRI_STRIP  = 2'd2,
    MODE_TRI_FAN    = 2'd3
  } prim_mode_t;

  typedef enum logic {
    CFG_IDX_PRIM_MODE    = 1'b0,
    CFG_IDX_PROVOKE_LAST = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    prim_mode_t prim_mode;
    logic       provoke_last;
  } cfg_t;

  // One queued command: a primitive, plus an optional loop-closing segment
  // that runs from vertex b back to close_ref.
  typedef struct packed {
    vref_t a;
    vref_t b;
    vref_t c;
    vref_t prov;
    logic  is_tri;
    logic  has_close;
    vref_t close_ref;
  } cmd_t;

  typedef enum logic [1:0] {
    PH_FIRST = 2'b01,
    PH_CLOSE = 2'b10
  } phase_t;

endpackage

`default_nettype wire

[design/pa_if.sv]
// Channel interfaces of the primitive assembler: vertex input and
// primitive output, each with valid/ready handshake. Depends on pa_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pa_in_if import pa_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [OUT_REF_W-1:0] vertex_ref;
  logic                 last_vertex;

  modport source (output valid, vertex_ref, last_vertex, input ready);
  modport sink (input valid, vertex_ref, last_vertex, output ready);
  modport monitor (input valid, ready, vertex_ref, last_vertex);
endinterface

interface pa_out_if import pa_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [OUT_REF_W-1:0] vert_a;
  logic [OUT_REF_W-1:0] vert_b;
  logic [OUT_REF_W-1:0] vert_c;
  logic [OUT_REF_W-1:0] provoking_ref;
  logic                 is_triangle;
  logic                 last_of_run;

  modport source (output valid, vert_a, vert_b, vert_c, provoking_ref, is_triangle,
                  last_of_run, input ready);
  modport sink (input valid, vert_a, vert_b, vert_c, provoking_ref, is_triangle,
                last_of_run, output ready);
  modport monitor (input valid, ready, vert_a, vert_b, vert_c, provoking_ref,
                   is_triangle, last_of_run);
endinterface

`default_nettype wire

[design/pa_front.sv]
// Front end: accepts vertices, tracks the draw state and turns each vertex
// into at most one queued command. Depends on pa_pkg and pa_in_if.
`timescale 1ns / 1ps
`default_nettype none

module pa_front import pa_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cfg_t cfg,
  pa_in_if.sink     in_vtx,
  input  wire logic q_ready,
  output logic      push,
  output cmd_t      cmd
);

  logic [SEEN_W-1:0] seen_r, seen_nxt;
  vref_t             anchor_r, anchor_nxt;
  vref_t             older_r, older_nxt;
  vref_t             newer_r, newer_nxt;
  logic              wind_r, wind_nxt;

  vref_t v;
  logic  last;
  logic  accept;
  logic  emit;
  logic  seen_one;
  logic  seen_two;

  assign in_vtx.ready = q_ready;
  assign accept       = in_vtx.valid & q_ready;
  assign v            = in_vtx.vertex_ref[REF_W-1:0];
  assign last         = in_vtx.last_vertex;
  assign seen_one     = (seen_r != '0);
  assign seen_two     = seen_r[1];

  always_comb begin
    cmd      = '0;
    emit     = 1'b0;
    wind_nxt = wind_r;
    unique case (cfg.prim_mode) inside
      MODE_LINE_STRIP, MODE_LINE_LOOP: begin
        emit          = seen_one;
        cmd.a         = newer_r;
        cmd.b         = v;
        cmd.has_close = (cfg.prim_mode == MODE_LINE_LOOP) & last;
        cmd.close_ref = anchor_r;
      end
      MODE_TRI_STRIP: begin
        emit       = seen_two;
        cmd.a      = wind_r ? newer_r : older_r;
        cmd.b      = wind_r ? older_r : newer_r;
        cmd.c      = v;
        cmd.prov   = cfg.provoke_last ? v : older_r;
        cmd.is_tri = 1'b1;
        if (seen_two) begin
          wind_nxt = ~wind_r;
        end
      end
      default: begin
        emit       = seen_two;
        cmd.a      = anchor_r;
        cmd.b      = newer_r;
        cmd.c      = v;
        cmd.prov   = cfg.provoke_last ? v : newer_r;
        cmd.is_tri = 1'b1;
      end
    endcase

    anchor_nxt = seen_one ? anchor_r : v;
    older_nxt  = newer_r;
    newer_nxt  = v;
    seen_nxt   = seen_two ? seen_r : seen_r + SEEN_W'(1);
    if (last) begin
      seen_nxt = '0;
      wind_nxt = 1'b0;
    end
  end

  assign push = accept & emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r   <= '0;
      anchor_r <= '0;
      older_r  <= '0;
      newer_r  <= '0;
      wind_r   <= 1'b0;
    end else if (accept) begin
      seen_r   <= seen_nxt;
      anchor_r <= anchor_nxt;
      older_r  <= older_nxt;
      newer_r  <= newer_nxt;
      wind_r   <= wind_nxt;
    end
  end

endmodule

`default_nettype wire

[design/pa_queue.sv]
// Small command queue between the front and back ends of the primitive
// assembler. Depends on pa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pa_queue import pa_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      not_full,
  output logic      not_empty,
  output cmd_t      head_cmd,
  input  wire logic pop
);

  cmd_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;

  assign not_full  = (count_r != Q_CNT_W'(Q_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_cmd  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PTR_W'(1);
    rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PTR_W'(1);
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + Q_CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

[design/pa_back.sv]
// Back end: takes commands from the queue and drives the output register,
// splitting a loop-closing command into two primitives. Depends on pa_pkg
// and pa_out_if.
`timescale 1ns / 1ps
`default_nettype none

module pa_back import pa_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  input  wire cmd_t q_cmd,
  output logic      pop,
  pa_out_if.source  out_prim
);

  phase_t phase_r, phase_nxt;
  logic   valid_r;
  vref_t  a_r, b_r, c_r, prov_r;
  logic   tri_r, last_r;
  logic   load;

  // The output register takes a new primitive whenever the queue holds one and
  // the register is empty or its current transaction completes in this cycle.
  assign load = q_valid & (~valid_r | out_prim.ready);

  always_comb begin
    phase_nxt = phase_r;
    pop       = 1'b0;
    if (load) begin
      unique case (phase_r)
        PH_FIRST: begin
          if (q_cmd.has_close) begin
            phase_nxt = PH_CLOSE;
          end else begin
            pop = 1'b1;
          end
        end
        PH_CLOSE: begin
          phase_nxt = PH_FIRST;
          pop       = 1'b1;
        end
        default: begin
          phase_nxt = PH_FIRST;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (load) begin
        valid_r <= 1'b1;
      end else if (out_prim.ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (phase_r == PH_CLOSE) begin
        a_r    <= q_cmd.b;
        b_r    <= q_cmd.close_ref;
        c_r    <= '0;
        prov_r <= '0;
        tri_r  <= 1'b0;
        last_r <= 1'b1;
      end else begin
        a_r    <= q_cmd.a;
        b_r    <= q_cmd.b;
        c_r    <= q_cmd.c;
        prov_r <= q_cmd.prov;
        tri_r  <= q_cmd.is_tri;
        last_r <= ~q_cmd.has_close;
      end
    end
  end

  assign out_prim.valid         = valid_r;
  assign out_prim.vert_a        = OUT_REF_W'(a_r);
  assign out_prim.vert_b        = OUT_REF_W'(b_r);
  assign out_prim.vert_c        = OUT_REF_W'(c_r);
  assign out_prim.provoking_ref = OUT_REF_W'(prov_r);
  assign out_prim.is_triangle   = tri_r;
  assign out_prim.last_of_run   = last_r;

endmodule

`default_nettype wire

[design/primitive_assembler_core.sv]
// Primitive assembler top level: configuration registers, front end,
// command queue and back end. Depends on pa_pkg, pa_if, pa_front,
// pa_queue and pa_back.
//
// Usage: vertices arrive on in_vtx (vertex_ref, last_vertex marks the end
// of a draw) and assembled primitives leave on out_prim. Both channels move
// a transaction when valid and ready are high at a rising edge of clk.
// The mode (line strip, line loop, triangle strip, triangle fan) and the
// provoking-vertex convention are written through cfg_we/cfg_index/cfg_wdata
// while the block is idle; they take effect on the next vertex.
// Throughput is one vertex per cycle while the queue is not full. A vertex
// yields at most one primitive, except the last vertex of a line loop, which
// yields two on consecutive cycles while out_prim does not stall. The front
// end is combinational and writes the queue at the edge that accepts the
// vertex; the back end then loads the command from the queue into the output
// register, which drives out_prim.
// A stalled receiver holds the output register; the four-entry queue keeps
// accepting vertices until it fills, then in_vtx.ready drops.
// Reset (rst_n low, synchronous) empties the queue and the output register,
// starts a new draw and sets line strip mode with last-vertex provoking.
`timescale 1ns / 1ps
`default_nettype none

module primitive_assembler_core import pa_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  pa_in_if.sink                      in_vtx,
  pa_out_if.source                   out_prim,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg_r;
  logic q_push;
  cmd_t q_push_cmd;
  logic q_not_full;
  logic q_not_empty;
  cmd_t q_head;
  logic q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prim_mode    <= MODE_LINE_STRIP;
      cfg_r.provoke_last <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_IDX_PRIM_MODE:    cfg_r.prim_mode    <= prim_mode_t'(cfg_wdata);
        CFG_IDX_PROVOKE_LAST: cfg_r.provoke_last <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  pa_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_vtx  (in_vtx),
    .q_ready (q_not_full),
    .push    (q_push),
    .cmd     (q_push_cmd)
  );

  pa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_push_cmd),
    .not_full  (q_not_full),
    .not_empty (q_not_empty),
    .head_cmd  (q_head),
    .pop       (q_pop)
  );

  pa_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_not_empty),
    .q_cmd    (q_head),
    .pop      (q_pop),
    .out_prim (out_prim)
  );

endmodule

`default_nettype wire

[design/pa_checker.sv]
// Port-level checker for the primitive assembler, bound to the top level.
// Depends on pa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pa_checker import pa_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 out_valid,
  input  wire logic                 out_ready,
  input  wire logic [OUT_REF_W-1:0] out_vert_a,
  input  wire logic [OUT_REF_W-1:0] out_vert_b,
  input  wire logic [OUT_REF_W-1:0] out_vert_c,
  input  wire logic [OUT_REF_W-1:0] out_provoking_ref,
  input  wire logic                 out_is_triangle,
  input  wire logic                 out_last_of_run
);

  logic out_fire;
  assign out_fire = out_valid & out_ready;

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_vert_a) && $stable(out_vert_b) &&
      $stable(out_last_of_run))
    else $error("stalled output changed");

  // A segment that is not the last of its run is followed at once by the
  // loop-closing segment that starts at its second vertex.
  a_loop_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && !out_last_of_run |=>
      out_valid && !out_is_triangle && out_last_of_run &&
      out_vert_a == $past(out_vert_b))
    else $error("loop closing segment missing or wrong");

  a_line_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_triangle |->
      out_vert_c == '0 && out_provoking_ref == '0)
    else $error("line primitive carries third or provoking vertex");

  a_tri_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_triangle |-> out_last_of_run)
    else $error("triangle not last of its run");

endmodule

bind primitive_assembler_core pa_checker u_pa_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_prim.valid),
  .out_ready         (out_prim.ready),
  .out_vert_a        (out_prim.vert_a),
  .out_vert_b        (out_prim.vert_b),
  .out_vert_c        (out_prim.vert_c),
  .out_provoking_ref (out_prim.provoking_ref),
  .out_is_triangle   (out_prim.is_triangle),
  .out_last_of_run   (out_prim.last_of_run)
);

`default_nettype wire
